>>> rtl/core/mals_pkg.sv
// Shared types, constants and character helpers for the address list splitter.
`timescale 1ns / 1ps

package mals_pkg;

  localparam int unsigned MaxLen = 4096;
  // Width of every offset field; holds 0 up to MaxLen.
  localparam int unsigned OfsW = 13;

  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChLAngle = 8'h3C;
  localparam logic [7:0] ChRAngle = 8'h3E;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_QUOTE   = 2'd2,
    MODE_ANGLE   = 2'd3
  } scan_mode_e;

  typedef struct packed {
    scan_mode_e            mode;
    logic [OfsW-1:0]       pos;
    logic                  has_bytes;
    logic                  beg_vld;
    logic [OfsW-1:0]       beg_pos;
    logic                  end_vld;
    logic [OfsW-1:0]       end_pos;
    logic                  fns_vld;
    logic [OfsW-1:0]       fns_pos;
    logic                  lns_vld;
    logic [OfsW-1:0]       lns_pos;
    logic [OfsW-1:0]       eln;  // last non-space before the end, plus one; zero for none
    logic                  ovf;
  } mals_state_t;

  typedef struct packed {
    logic            found;
    logic [OfsW-1:0] addr_begin;
    logic [OfsW-1:0] addr_end;
    logic [OfsW-1:0] token_end;
    logic            buffer_done;
    logic            overflow;
  } mals_result_t;

  localparam mals_state_t StateReset = '{
    mode: MODE_NORMAL, pos: '0, has_bytes: 1'b0, beg_vld: 1'b0, beg_pos: '0,
    end_vld: 1'b0, end_pos: '0, fns_vld: 1'b0, fns_pos: '0, lns_vld: 1'b0,
    lns_pos: '0, eln: '0, ovf: 1'b0
  };

  function automatic logic [OfsW-1:0] sat_inc(input logic [OfsW-1:0] v);
    logic [OfsW-1:0] r;
    if (v >= OfsW'(MaxLen)) begin
      r = OfsW'(MaxLen);
    end else begin
      r = v + 1'b1;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic starts_addr(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == ChDot) || (c == ChUscore);
  endfunction

endpackage

>>> rtl/core/mals_step.sv
// Per-byte update of the token state and formation of the token result.
`timescale 1ns / 1ps

module mals_step (
  input  mals_pkg::mals_state_t  state_i,
  input  logic [7:0]             ch_i,
  input  logic                   end_of_text_i,
  output mals_pkg::mals_state_t  state_o,
  output logic                   emit_o,
  output mals_pkg::mals_result_t result_o
);
  import mals_pkg::*;

  logic [OfsW-1:0] p;
  logic [OfsW-1:0] nxt;
  logic            at_max;
  logic            is_comma;

  // Closes the token: an open address ends at the token end, then trimming applies.
  function automatic mals_result_t close_token(input mals_state_t s,
                                               input logic [OfsW-1:0] tend,
                                               input logic done, input logic ovf);
    mals_result_t    r;
    logic [OfsW-1:0] ep;
    logic [OfsW-1:0] eln;
    ep  = s.end_pos;
    eln = s.eln;
    if (s.beg_vld && !s.end_vld) begin
      ep  = tend;
      eln = s.lns_vld ? sat_inc(s.lns_pos) : '0;
    end
    r.found       = s.beg_vld;
    r.addr_begin  = '0;
    r.addr_end    = '0;
    if (s.beg_vld) begin
      if (eln != '0) begin
        r.addr_begin = s.fns_pos;
        r.addr_end   = eln;
      end else begin
        r.addr_begin = ep;
        r.addr_end   = ep;
      end
    end
    r.token_end   = tend;
    r.buffer_done = done;
    r.overflow    = ovf;
    return r;
  endfunction

  // Positions saturate at MaxLen, so the current position is the byte offset.
  assign p        = state_i.pos;
  assign at_max   = (state_i.pos >= OfsW'(MaxLen));
  assign nxt      = sat_inc(p);
  assign is_comma = (state_i.mode == MODE_NORMAL) && (ch_i == ChComma);

  // Result formation.
  always_comb begin
    emit_o   = 1'b0;
    result_o = close_token(state_i, p, 1'b0, state_i.ovf | at_max);
    if (end_of_text_i) begin
      emit_o   = state_i.has_bytes;
      result_o = close_token(state_i, state_i.pos, 1'b1, state_i.ovf);
    end else if (is_comma) begin
      emit_o = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_o = state_i;
    if (end_of_text_i) begin
      state_o = StateReset;
    end else if (is_comma) begin
      state_o      = StateReset;
      state_o.pos  = nxt;
      state_o.ovf  = state_i.ovf | at_max;
    end else begin
      state_o.ovf = state_i.ovf | at_max;
      case (state_i.mode)
        MODE_NORMAL: begin
          if (ch_i == ChLParen) begin
            if (state_i.beg_vld && !state_i.end_vld) begin
              state_o.end_vld = 1'b1;
              state_o.end_pos = p;
              state_o.eln     = state_i.lns_vld ? sat_inc(state_i.lns_pos) : '0;
            end
            state_o.mode = MODE_COMMENT;
          end else if (ch_i == ChQuote) begin
            if (!state_i.beg_vld) begin
              state_o.beg_vld = 1'b1;
              state_o.beg_pos = nxt;
              state_o.fns_vld = 1'b0;
              state_o.lns_vld = 1'b0;
            end
            state_o.mode = MODE_QUOTE;
          end else if (ch_i == ChLAngle) begin
            // An angle span always restarts the address and drops any earlier end.
            state_o.beg_vld = 1'b1;
            state_o.beg_pos = nxt;
            state_o.fns_vld = 1'b0;
            state_o.lns_vld = 1'b0;
            state_o.end_vld = 1'b0;
            state_o.end_pos = '0;
            state_o.eln     = '0;
            state_o.mode    = MODE_ANGLE;
          end else if (!state_i.beg_vld && starts_addr(ch_i)) begin
            state_o.beg_vld = 1'b1;
            state_o.beg_pos = p;
            state_o.fns_vld = 1'b0;
            state_o.lns_vld = 1'b0;
          end
        end
        MODE_COMMENT: begin
          if (ch_i == ChRParen) begin
            state_o.mode = MODE_NORMAL;
          end
        end
        MODE_QUOTE: begin
          if (ch_i == ChQuote) begin
            if (!state_i.end_vld) begin
              state_o.end_vld = 1'b1;
              state_o.end_pos = p;
              state_o.eln     = state_i.lns_vld ? sat_inc(state_i.lns_pos) : '0;
            end
            state_o.mode = MODE_NORMAL;
          end
        end
        default: begin
          if (ch_i == ChRAngle) begin
            state_o.end_vld = 1'b1;
            state_o.end_pos = p;
            state_o.eln     = state_i.lns_vld ? sat_inc(state_i.lns_pos) : '0;
            state_o.mode    = MODE_NORMAL;
          end
        end
      endcase

      // Trim tracking uses the begin as updated by this byte.
      if (state_o.beg_vld && (state_o.beg_pos <= p) && !is_space(ch_i)) begin
        if (!state_o.fns_vld) begin
          state_o.fns_vld = 1'b1;
          state_o.fns_pos = p;
        end
        state_o.lns_vld = 1'b1;
        state_o.lns_pos = p;
      end
      state_o.has_bytes = 1'b1;
      state_o.pos       = nxt;
    end
  end

endmodule

>>> rtl/core/mail_address_list_splitter.sv
// Timing: a token result appears on the output register in the cycle after the
// comma or end-of-text word that closes the token is accepted.
// Throughput: one input word per cycle; the scan state and the output register
// are the only storage, so input stalls only while a result waits to be taken.
// Reset: rst_ni clears the scan state and the output valid at once.
`timescale 1ns / 1ps

module mail_address_list_splitter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 ch_i,
  input  logic                       end_of_text_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       found_o,
  output logic [mals_pkg::OfsW-1:0]  addr_begin_o,
  output logic [mals_pkg::OfsW-1:0]  addr_end_o,
  output logic [mals_pkg::OfsW-1:0]  token_end_o,
  output logic                       buffer_done_o,
  output logic                       overflow_o
);
  import mals_pkg::*;

  mals_state_t  state_q;
  mals_state_t  state_d;
  mals_state_t  step_state;
  mals_result_t step_result;
  mals_result_t result_q;
  logic         step_emit;
  logic         out_valid_q;
  logic         out_valid_d;
  logic         in_accept;

  mals_step u_step (
    .state_i       (state_q),
    .ch_i          (ch_i),
    .end_of_text_i (end_of_text_i),
    .state_o       (step_state),
    .emit_o        (step_emit),
    .result_o      (step_result)
  );

  // A new word is taken whenever the output register is free or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = in_accept ? step_state : state_q;
    out_valid_d = in_accept ? step_emit : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && step_emit) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = result_q.found;
  assign addr_begin_o  = result_q.addr_begin;
  assign addr_end_o    = result_q.addr_end;
  assign token_end_o   = result_q.token_end;
  assign buffer_done_o = result_q.buffer_done;
  assign overflow_o    = result_q.overflow;

`ifndef SYNTH
  a_eot_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && end_of_text_i) |=> (state_q.pos == '0 && state_q.mode == MODE_NORMAL))
    else $error("scan state not restarted after end of text");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos <= OfsW'(MaxLen))
    else $error("position ran past the saturation limit");

  a_no_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (addr_begin_o == '0 && addr_end_o == '0))
    else $error("address offsets nonzero without an address");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (token_end_o == OfsW'(MaxLen)))
    else $error("overflowed token end not saturated");
`endif

endmodule

>>> tb/mail_address_list_splitter_tb.sv
// Self-checking testbench for the mail address list splitter: directed and random header text.
`timescale 1ns / 1ps

module mail_address_list_splitter_tb;
  import mals_pkg::*;

  localparam logic [OfsW-1:0] LenCap = OfsW'(MaxLen);
  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned PhaseWords = 425;
  localparam logic [7:0] ChAt = "@";
  localparam logic [7:0] ChDash = "-";

  // Tracks the scan of the header text and holds the token results still to come.
  class token_scoreboard;
    mals_result_t expected_tokens[$];
    scan_mode_e mode;
    logic [OfsW-1:0] pos, beg_pos, end_pos, fns_pos, lns_pos, end_trim;
    bit has_bytes, beg_vld, end_vld, fns_vld, lns_vld, ovf;
    int unsigned errors, checked, with_addr, with_ovf, reports;

    function new();
      errors = 0;
      checked = 0;
      with_addr = 0;
      with_ovf = 0;
      reports = 0;
      restart();
    endfunction

    function void clear_token();
      has_bytes = 1'b0;
      beg_vld = 1'b0;
      beg_pos = '0;
      end_vld = 1'b0;
      end_pos = '0;
      fns_vld = 1'b0;
      fns_pos = '0;
      lns_vld = 1'b0;
      lns_pos = '0;
      end_trim = '0;
    endfunction

    function void restart();
      clear_token();
      mode = MODE_NORMAL;
      pos = '0;
      ovf = 1'b0;
    endfunction

    function logic [OfsW-1:0] step_up(logic [OfsW-1:0] v);
      return (v >= LenCap) ? LenCap : v + 1'b1;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit opens_addr(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == ChDot || c == ChUscore;
    endfunction

    function void mark_begin(logic [OfsW-1:0] b);
      beg_vld = 1'b1;
      beg_pos = b;
      fns_vld = 1'b0;
      lns_vld = 1'b0;
    endfunction

    function void mark_end(logic [OfsW-1:0] e);
      end_vld = 1'b1;
      end_pos = e;
      end_trim = lns_vld ? step_up(lns_pos) : '0;
    endfunction

    function void push_token(logic [OfsW-1:0] tend, bit done);
      mals_result_t r;
      r = '0;
      if (beg_vld && !end_vld) mark_end(tend);
      if (beg_vld) begin
        // A span without any non-space byte collapses onto its untrimmed end.
        if (end_trim != '0) begin
          r.addr_begin = fns_pos;
          r.addr_end = end_trim;
        end else begin
          r.addr_begin = end_pos;
          r.addr_end = end_pos;
        end
      end
      r.found = beg_vld;
      r.token_end = tend;
      r.buffer_done = done;
      r.overflow = ovf;
      expected_tokens.push_back(r);
    endfunction

    function void note_word(logic [7:0] c, bit eot);
      logic [OfsW-1:0] p, nxt;
      if (eot) begin
        if (has_bytes) push_token(pos, 1'b1);
        restart();
        return;
      end
      p = pos;
      if (p >= LenCap) begin
        p = LenCap;
        ovf = 1'b1;
      end
      nxt = step_up(p);
      case (mode)
        MODE_NORMAL: begin
          if (c == ChComma) begin
            push_token(p, 1'b0);
            clear_token();
            pos = nxt;
            return;
          end else if (c == ChLParen) begin
            if (beg_vld && !end_vld) mark_end(p);
            mode = MODE_COMMENT;
          end else if (c == ChQuote) begin
            if (!beg_vld) mark_begin(nxt);
            mode = MODE_QUOTE;
          end else if (c == ChLAngle) begin
            // An angle bracket wins over anything found so far, including an end.
            mark_begin(nxt);
            end_vld = 1'b0;
            end_pos = '0;
            end_trim = '0;
            mode = MODE_ANGLE;
          end else if (!beg_vld && opens_addr(c)) begin
            mark_begin(p);
          end
        end
        MODE_COMMENT: begin
          if (c == ChRParen) mode = MODE_NORMAL;
        end
        MODE_QUOTE: begin
          if (c == ChQuote) begin
            if (!end_vld) mark_end(p);
            mode = MODE_NORMAL;
          end
        end
        default: begin
          if (c == ChRAngle) begin
            mark_end(p);
            mode = MODE_NORMAL;
          end
        end
      endcase
      if (beg_vld && beg_pos <= p && !is_blank(c)) begin
        if (!fns_vld) begin
          fns_vld = 1'b1;
          fns_pos = p;
        end
        lns_vld = 1'b1;
        lns_pos = p;
      end
      has_bytes = 1'b1;
      pos = nxt;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (reports < 40) begin
          reports++;
          $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
      end
    endfunction

    function void check_token(mals_result_t got);
      mals_result_t want;
      if (expected_tokens.size() == 0) begin
        errors++;
        if (reports < 40) begin
          reports++;
          $display("%0t: unexpected result, expected none, got %p", $time, got);
        end
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (want.found) with_addr++;
      if (want.overflow) with_ovf++;
      compare_field("found", want.found, got.found);
      compare_field("addr_begin", want.addr_begin, got.addr_begin);
      compare_field("addr_end", want.addr_end, got.addr_end);
      compare_field("token_end", want.token_end, got.token_end);
      compare_field("buffer_done", want.buffer_done, got.buffer_done);
      compare_field("overflow", want.overflow, got.overflow);
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [7:0] ch_i;
  logic end_of_text_i;
  logic out_valid_o;
  logic out_ready_i;
  logic found_o;
  logic [OfsW-1:0] addr_begin_o;
  logic [OfsW-1:0] addr_end_o;
  logic [OfsW-1:0] token_end_o;
  logic buffer_done_o;
  logic overflow_o;

  token_scoreboard sb;
  mals_result_t seen;
  logic [7:0] text_q[$];
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned words_sent;
  int unsigned buffers_sent;
  int unsigned cycles;

  mail_address_list_splitter DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .ch_i(ch_i),
    .end_of_text_i(end_of_text_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .found_o(found_o),
    .addr_begin_o(addr_begin_o),
    .addr_end_o(addr_end_o),
    .token_end_o(token_end_o),
    .buffer_done_o(buffer_done_o),
    .overflow_o(overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= LimitCycles) begin
        $display("%0t: timed out with %0d results outstanding", $time, sb.pending());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= stall_pct);
    end
  end

  // Both handshakes are observed here, the input first, so a result is never
  // checked ahead of the word that predicts it.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (in_valid_i && in_ready_o) sb.note_word(ch_i, end_of_text_i);
        if (out_valid_o && out_ready_i) begin
          seen.found = found_o;
          seen.addr_begin = addr_begin_o;
          seen.addr_end = addr_end_o;
          seen.token_end = token_end_o;
          seen.buffer_done = buffer_done_o;
          seen.overflow = overflow_o;
          sb.check_token(seen);
        end
      end
    end
  end

  // Entered and left just after a falling edge.
  task automatic send_word(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    ch_i = c;
    end_of_text_i = eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_word(text_q[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
    text_q.delete();
    buffers_sent++;
  endtask

  function automatic void put_str(string s);
    foreach (s[i]) text_q.push_back(s[i]);
  endfunction

  function automatic void put_blanks(int unsigned most);
    int unsigned n;
    n = $urandom_range(0, most);
    repeat (n) begin
      if ($urandom_range(0, 3) != 0) text_q.push_back(ChSpace);
      else text_q.push_back(8'(ChTab + $urandom_range(0, 4)));
    end
  endfunction

  function automatic void put_word();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0, 1, 2: text_q.push_back(8'("a" + $urandom_range(0, 25)));
        3: text_q.push_back(8'("A" + $urandom_range(0, 25)));
        4: text_q.push_back(8'("0" + $urandom_range(0, 9)));
        default: begin
          case ($urandom_range(0, 2))
            0: text_q.push_back(ChDot);
            1: text_q.push_back(ChUscore);
            default: text_q.push_back(ChDash);
          endcase
        end
      endcase
    end
  endfunction

  function automatic void put_addr();
    put_word();
    text_q.push_back(ChAt);
    put_word();
  endfunction

  function automatic void put_angle_addr();
    text_q.push_back(ChLAngle);
    put_blanks(1);
    put_addr();
    put_blanks(1);
    text_q.push_back(ChRAngle);
  endfunction

  // One entry of an address list; most are well formed, a few are broken or raw noise.
  function automatic void put_token();
    int unsigned n;
    put_blanks(2);
    case ($urandom_range(0, 9))
      0: put_addr();
      1: begin
        put_word();
        put_blanks(2);
        put_word();
        put_blanks(2);
        put_angle_addr();
      end
      2: begin
        text_q.push_back(ChQuote);
        put_word();
        text_q.push_back(ChComma);
        put_blanks(1);
        put_word();
        text_q.push_back(ChQuote);
        put_blanks(2);
        put_angle_addr();
      end
      3: begin
        put_addr();
        put_blanks(2);
        text_q.push_back(ChLParen);
        put_word();
        text_q.push_back(ChComma);
        put_word();
        text_q.push_back(ChRParen);
      end
      4: begin
        text_q.push_back(ChQuote);
        put_blanks(2);
        put_word();
        put_blanks(2);
        text_q.push_back(ChQuote);
      end
      5: ;
      6: begin
        text_q.push_back(ChLAngle);
        put_blanks(2);
        if ($urandom_range(0, 1)) put_addr();
        if ($urandom_range(0, 1)) text_q.push_back(ChRAngle);
      end
      7: begin
        n = $urandom_range(1, 8);
        repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
      end
      8: begin
        text_q.push_back(8'("0" + $urandom_range(0, 9)));
        put_blanks(1);
        put_addr();
        if ($urandom_range(0, 1)) text_q.push_back(ChQuote);
      end
      default: begin
        text_q.push_back(ChLParen);
        put_word();
        if ($urandom_range(0, 3) != 0) text_q.push_back(ChRParen);
        text_q.push_back(ChQuote);
        put_word();
        text_q.push_back(ChQuote);
        put_angle_addr();
      end
    endcase
    put_blanks(2);
  endfunction

  task automatic send_random_buffer();
    int unsigned ntok;
    ntok = $urandom_range(1, 4);
    for (int unsigned t = 0; t < ntok; t++) begin
      put_token();
      if (t + 1 < ntok) text_q.push_back(ChComma);
    end
    if ($urandom_range(0, 9) == 0) text_q.push_back(ChComma);
    send_text();
    if ($urandom_range(0, 19) == 0) send_text();
  endtask

  // Fills one buffer to exactly len bytes; the cut may leave a span open.
  task automatic send_long_buffer(input int unsigned len);
    while (text_q.size() < len) begin
      put_token();
      text_q.push_back(ChComma);
    end
    while (text_q.size() > len) void'(text_q.pop_back());
    send_text();
  endtask

  initial begin
    int unsigned phase_start;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    ch_i = '0;
    end_of_text_i = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    words_sent = 0;
    buffers_sent = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty buffer, empty tokens, comment closing an address, unclosed angle,
    // quote followed by extreme byte values, and an angle holding only spaces.
    send_text();
    put_str(" , ");
    send_text();
    put_str("a(c)<b");
    send_text();
    put_str("\"q\" ");
    text_q.push_back(8'hFF);
    text_q.push_back(8'h00);
    send_text();
    put_str("< \t>");
    send_text();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 68;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 68;
        end
        default: begin
          send_idle_pct = 37;
          stall_pct = 37;
        end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < PhaseWords) send_random_buffer();
      if (ph == 1) send_long_buffer(MaxLen);
      if (ph == 3) send_long_buffer(MaxLen + 1 + $urandom_range(0, 30));
    end
    in_valid_i = 1'b0;
    stall_pct = 0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d words in %0d buffers, including two of maximum length and beyond.",
             words_sent, buffers_sent);
    $display("Checked %0d token results: %0d held an address, %0d flagged overflow.",
             sb.checked, sb.with_addr, sb.with_ovf);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
